>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/pnht_pkg.sv
// Package of the pitch note hypothesis tracker: widths, codes and types.
package pnht_pkg;

  localparam int unsigned FreqW    = 20;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ConfW    = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned FsumW    = 36;
  localparam int unsigned CsumW    = 32;
  localparam int unsigned RatioW   = 17;
  localparam int unsigned GapW     = 20;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned StateW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Shared arithmetic unit widths
  localparam int unsigned MulAW = 53;
  localparam int unsigned MulBW = 32;
  localparam int unsigned DivNW = 37;
  localparam int unsigned DivDW = 16;
  localparam int unsigned StepW = 6;

  localparam logic [CountW-1:0] MaxEstimates  = 16'd65535;
  localparam logic [CountW-1:0] DefaultLength = 16'd10000;

  localparam logic [GapW-1:0]   MaxGapRst        = 20'd40000;
  localparam logic [RatioW-1:0] NearRatioHighRst = 17'd67867;
  localparam logic [RatioW-1:0] NearRatioLowRst  = 17'd63285;
  localparam logic [RatioW-1:0] MeanRatioHighRst = 17'd68655;
  localparam logic [RatioW-1:0] MeanRatioLowRst  = 17'd62558;
  localparam logic [ScaleW-1:0] LengthScaleRst   = 16'd512;

  typedef enum logic [StateW-1:0] {
    PhNew  = 3'd0,
    PhProv = 3'd1,
    PhSat  = 3'd2,
    PhRej  = 3'd3,
    PhExp  = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxGap        = 3'd0,
    CfgNearRatioHigh = 3'd1,
    CfgNearRatioLow  = 3'd2,
    CfgMeanRatioHigh = 3'd3,
    CfgMeanRatioLow  = 3'd4,
    CfgLengthScale   = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    AluMul = 1'b0,
    AluDiv = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [MulAW-1:0] res;
  } alu_rsp_t;

endpackage

>>> hw/rtl/pnht_ifs.sv
// Channel interfaces of the pitch note hypothesis tracker.
interface pnht_est_if;
  logic                        valid;
  logic                        ready;
  logic [pnht_pkg::FreqW-1:0]  frequency;
  logic [pnht_pkg::TimeW-1:0]  time_stamp;
  logic [pnht_pkg::ConfW-1:0]  confidence;
  modport source (output valid, frequency, time_stamp, confidence, input ready);
  modport sink   (input valid, frequency, time_stamp, confidence, output ready);
endinterface

interface pnht_res_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [pnht_pkg::StateW-1:0] hyp_state;
  logic                        note_valid;
  logic [pnht_pkg::TimeW-1:0]  note_start;
  logic [pnht_pkg::TimeW-1:0]  note_duration;
  logic [pnht_pkg::FreqW-1:0]  mean_frequency;
  modport source (output valid, accepted, hyp_state, note_valid, note_start,
                  note_duration, mean_frequency, input ready);
  modport sink   (input valid, accepted, hyp_state, note_valid, note_start,
                  note_duration, mean_frequency, output ready);
endinterface

interface pnht_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pnht_pkg::CfgIdxW-1:0]  index;
  logic [pnht_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pitch_note_hypothesis_tracker.sv
// Pitch note hypothesis tracker: one estimate in, one hypothesis status out.
// Each estimate is worked on alone; est_i is ready only when the block is
// idle. The ratio tests, the required-length test and the mean frequency all
// run through one shift-add multiplier / restoring divider. A multiply steps
// through the significant bits of its second operand (up to 17 for ratios,
// up to 16 for counts), and the mean divide through the 37 dividend bits.
// Each result is held on res_o until res_o.ready takes it.
// Configuration writes are taken at any time and are registered directly.
module pitch_note_hypothesis_tracker (
  input  logic clk_i,
  input  logic rst_ni,
  pnht_est_if.sink   est_i,
  pnht_res_if.source res_o,
  pnht_cfg_if.sink   cfg_i
);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SEval    = 4'd1;
  localparam logic [3:0] SNearLo  = 4'd2;
  localparam logic [3:0] SNearHi  = 4'd3;
  localparam logic [3:0] SFn      = 4'd4;
  localparam logic [3:0] SMeanLo  = 4'd5;
  localparam logic [3:0] SMeanHi  = 4'd6;
  localparam logic [3:0] STake    = 4'd7;
  localparam logic [3:0] SLenChk  = 4'd8;
  localparam logic [3:0] SLenMul  = 4'd9;
  localparam logic [3:0] SLenCmp  = 4'd10;
  localparam logic [3:0] SFinish  = 4'd11;
  localparam logic [3:0] SDiv     = 4'd12;
  localparam logic [3:0] SOut     = 4'd13;

  localparam int unsigned XW = 42;

  // Configuration registers
  logic [pnht_pkg::GapW-1:0]   max_gap_q;
  logic [pnht_pkg::RatioW-1:0] near_hi_q, near_lo_q, mean_hi_q, mean_lo_q;
  logic [pnht_pkg::ScaleW-1:0] scale_q;

  // Hypothesis state
  pnht_pkg::phase_e            phase_q, phase_d;
  logic [pnht_pkg::CountW-1:0] count_q;
  logic [pnht_pkg::FsumW-1:0]  fsum_q;
  logic [pnht_pkg::CsumW-1:0]  csum_q;
  logic [pnht_pkg::FreqW-1:0]  lastf_q;
  logic [pnht_pkg::TimeW-1:0]  lastt_q, firstt_q;

  // Sequencer and item registers
  logic [3:0]                  seq_q, seq_d;
  logic                        took_q, took_d;
  logic [pnht_pkg::FreqW-1:0]  f_q;
  logic [pnht_pkg::TimeW-1:0]  t_q;
  logic [pnht_pkg::ConfW-1:0]  c_q;
  logic [pnht_pkg::FsumW-1:0]  fn_q, fn_d;
  logic [XW-1:0]               x_q, x_d;
  logic                        take;
  logic                        out_load;
  logic                        out_zero;

  // Result registers
  logic [pnht_pkg::TimeW-1:0]  start_q, dur_q;
  logic [pnht_pkg::FreqW-1:0]  mean_q;

  pnht_pkg::alu_req_t          alu_req;
  pnht_pkg::alu_rsp_t          alu_rsp;

  logic [pnht_pkg::TimeW-1:0]  gap;
  logic [pnht_pkg::MulAW-1:0]  f_sh, fn_sh;
  logic                        note_ok;

  pnht_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign gap   = t_q - lastt_q;
  assign f_sh  = pnht_pkg::MulAW'({f_q, 16'b0});
  assign fn_sh = pnht_pkg::MulAW'({fn_q, 16'b0});
  assign note_ok = (phase_q == pnht_pkg::PhSat) || (phase_q == pnht_pkg::PhExp);

  // Configuration writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q <= pnht_pkg::MaxGapRst;
      near_hi_q <= pnht_pkg::NearRatioHighRst;
      near_lo_q <= pnht_pkg::NearRatioLowRst;
      mean_hi_q <= pnht_pkg::MeanRatioHighRst;
      mean_lo_q <= pnht_pkg::MeanRatioLowRst;
      scale_q   <= pnht_pkg::LengthScaleRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pnht_pkg::CfgMaxGap:        max_gap_q <= cfg_i.data[pnht_pkg::GapW-1:0];
        pnht_pkg::CfgNearRatioHigh: near_hi_q <= cfg_i.data[pnht_pkg::RatioW-1:0];
        pnht_pkg::CfgNearRatioLow:  near_lo_q <= cfg_i.data[pnht_pkg::RatioW-1:0];
        pnht_pkg::CfgMeanRatioHigh: mean_hi_q <= cfg_i.data[pnht_pkg::RatioW-1:0];
        pnht_pkg::CfgMeanRatioLow:  mean_lo_q <= cfg_i.data[pnht_pkg::RatioW-1:0];
        pnht_pkg::CfgLengthScale:   scale_q   <= cfg_i.data[pnht_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign est_i.ready = (seq_q == SIdle);

  // Sequencer
  always_comb begin
    seq_d    = seq_q;
    phase_d  = phase_q;
    took_d   = took_q;
    fn_d     = fn_q;
    x_d      = x_q;
    take     = 1'b0;
    out_load = 1'b0;
    out_zero = 1'b0;
    alu_req  = '{start: 1'b0, op: pnht_pkg::AluMul, a: '0, b: '0};
    unique case (seq_q)
      SIdle: begin
        if (est_i.valid) seq_d = SEval;
      end
      SEval: begin
        took_d = 1'b0;
        case (phase_q)
          pnht_pkg::PhNew: begin
            phase_d = pnht_pkg::PhProv;
            took_d  = 1'b1;
            seq_d   = STake;
          end
          pnht_pkg::PhProv, pnht_pkg::PhSat: begin
            if (count_q != '0 && gap > pnht_pkg::TimeW'(max_gap_q)) begin
              phase_d = (phase_q == pnht_pkg::PhProv) ? pnht_pkg::PhRej
                                                      : pnht_pkg::PhExp;
              seq_d   = SFinish;
            end else if (count_q == '0) begin
              took_d = 1'b1;
              seq_d  = STake;
            end else begin
              alu_req = '{start: 1'b1, op: pnht_pkg::AluMul,
                          a: pnht_pkg::MulAW'(lastf_q), b: pnht_pkg::MulBW'(near_lo_q)};
              seq_d   = SNearLo;
            end
          end
          default: seq_d = SFinish;
        endcase
      end
      SNearLo: begin
        if (alu_rsp.done) begin
          if (f_sh < alu_rsp.res) begin
            seq_d = SFinish;
          end else begin
            alu_req = '{start: 1'b1, op: pnht_pkg::AluMul,
                        a: pnht_pkg::MulAW'(lastf_q), b: pnht_pkg::MulBW'(near_hi_q)};
            seq_d   = SNearHi;
          end
        end
      end
      SNearHi: begin
        if (alu_rsp.done) begin
          if (f_sh > alu_rsp.res) begin
            seq_d = SFinish;
          end else begin
            alu_req = '{start: 1'b1, op: pnht_pkg::AluMul,
                        a: pnht_pkg::MulAW'(f_q), b: pnht_pkg::MulBW'(count_q)};
            seq_d   = SFn;
          end
        end
      end
      SFn: begin
        if (alu_rsp.done) begin
          fn_d    = alu_rsp.res[pnht_pkg::FsumW-1:0];
          alu_req = '{start: 1'b1, op: pnht_pkg::AluMul,
                      a: pnht_pkg::MulAW'(fsum_q), b: pnht_pkg::MulBW'(mean_lo_q)};
          seq_d   = SMeanLo;
        end
      end
      SMeanLo: begin
        if (alu_rsp.done) begin
          if (fn_sh < alu_rsp.res) begin
            seq_d = SFinish;
          end else begin
            alu_req = '{start: 1'b1, op: pnht_pkg::AluMul,
                        a: pnht_pkg::MulAW'(fsum_q), b: pnht_pkg::MulBW'(mean_hi_q)};
            seq_d   = SMeanHi;
          end
        end
      end
      SMeanHi: begin
        if (alu_rsp.done) begin
          if (fn_sh > alu_rsp.res) begin
            seq_d = SFinish;
          end else begin
            took_d = 1'b1;
            seq_d  = STake;
          end
        end
      end
      STake: begin
        take  = 1'b1;
        seq_d = SLenChk;
      end
      SLenChk: begin
        // Satisfied once count > round(256 * scale / mean confidence)
        if (phase_q != pnht_pkg::PhProv) begin
          seq_d = SFinish;
        end else if (csum_q == '0) begin
          if (count_q > pnht_pkg::DefaultLength) phase_d = pnht_pkg::PhSat;
          seq_d = SFinish;
        end else begin
          alu_req = '{start: 1'b1, op: pnht_pkg::AluMul,
                      a: pnht_pkg::MulAW'(scale_q), b: pnht_pkg::MulBW'(count_q)};
          seq_d   = SLenMul;
        end
      end
      SLenMul: begin
        if (alu_rsp.done) begin
          x_d     = XW'({alu_rsp.res[31:0], 9'b0}) + XW'(csum_q);
          alu_req = '{start: 1'b1, op: pnht_pkg::AluMul,
                      a: pnht_pkg::MulAW'(csum_q), b: pnht_pkg::MulBW'(count_q)};
          seq_d   = SLenCmp;
        end
      end
      SLenCmp: begin
        if (alu_rsp.done) begin
          // n > floor(x / 2C) exactly when 2 n C > x
          if ({alu_rsp.res[47:0], 1'b0} > 49'(x_q)) phase_d = pnht_pkg::PhSat;
          seq_d = SFinish;
        end
      end
      SFinish: begin
        if (note_ok && count_q != '0) begin
          alu_req = '{start: 1'b1, op: pnht_pkg::AluDiv,
                      a: pnht_pkg::MulAW'(pnht_pkg::DivNW'(fsum_q)
                         + pnht_pkg::DivNW'(count_q[pnht_pkg::CountW-1:1])),
                      b: pnht_pkg::MulBW'(count_q)};
          seq_d   = SDiv;
        end else begin
          out_load = 1'b1;
          out_zero = 1'b1;
          seq_d    = SOut;
        end
      end
      SDiv: begin
        if (alu_rsp.done) begin
          out_load = 1'b1;
          seq_d    = SOut;
        end
      end
      SOut: begin
        if (res_o.ready) seq_d = SIdle;
      end
      default: seq_d = SIdle;
    endcase
  end

  // Control and hypothesis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= SIdle;
      phase_q  <= pnht_pkg::PhNew;
      took_q   <= 1'b0;
      count_q  <= '0;
      fsum_q   <= '0;
      csum_q   <= '0;
      lastf_q  <= '0;
      lastt_q  <= '0;
      firstt_q <= '0;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      took_q  <= took_d;
      if (take) begin
        if (count_q == '0) firstt_q <= t_q;
        if (count_q < pnht_pkg::MaxEstimates) begin
          count_q <= count_q + 1'b1;
          fsum_q  <= fsum_q + pnht_pkg::FsumW'(f_q);
          csum_q  <= csum_q + pnht_pkg::CsumW'(c_q);
        end
        lastf_q <= f_q;
        lastt_q <= t_q;
      end
    end
  end

  // Item and scratch registers
  always_ff @(posedge clk_i) begin
    if (seq_q == SIdle && est_i.valid) begin
      f_q <= est_i.frequency;
      t_q <= est_i.time_stamp;
      c_q <= est_i.confidence;
    end
    fn_q <= fn_d;
    x_q  <= x_d;
    if (out_load) begin
      if (out_zero) begin
        start_q <= '0;
        dur_q   <= '0;
        mean_q  <= '0;
      end else begin
        start_q <= firstt_q;
        dur_q   <= lastt_q - firstt_q;
        mean_q  <= alu_rsp.res[pnht_pkg::FreqW-1:0];
      end
    end
  end

  assign res_o.valid          = (seq_q == SOut);
  assign res_o.accepted       = took_q;
  assign res_o.hyp_state      = phase_q;
  assign res_o.note_valid     = note_ok;
  assign res_o.note_start     = start_q;
  assign res_o.note_duration  = dur_q;
  assign res_o.mean_frequency = mean_q;

endmodule

>>> hw/rtl/pnht_alu.sv
// Shared iterative unit: shift-add multiplier and restoring divider.
module pnht_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pnht_pkg::alu_req_t req_i,
  output pnht_pkg::alu_rsp_t rsp_o
);

  logic                             busy_q;
  pnht_pkg::alu_op_e                op_q;
  logic [pnht_pkg::StepW-1:0]       step_q;
  logic [pnht_pkg::MulAW-1:0]       a_q;
  logic [pnht_pkg::MulBW-1:0]       b_q;
  logic [pnht_pkg::MulAW-1:0]       acc_q;
  logic [pnht_pkg::DivDW-1:0]       rem_q;
  logic [pnht_pkg::DivDW:0]         rem_n;
  logic [pnht_pkg::DivDW:0]         diff;
  logic                             ge;
  logic                             mul_done;
  logic                             div_done;

  // One divider step: shift in next dividend bit, trial subtract
  assign rem_n = {rem_q, a_q[pnht_pkg::DivNW-1]};
  assign ge    = rem_n >= {1'b0, b_q[pnht_pkg::DivDW-1:0]};
  assign diff  = rem_n - {1'b0, b_q[pnht_pkg::DivDW-1:0]};

  // Multiply ends once no multiplier bits remain
  assign mul_done = busy_q && (op_q == pnht_pkg::AluMul) && (b_q == '0);
  assign div_done = busy_q && (op_q == pnht_pkg::AluDiv) && (step_q == '0);

  assign rsp_o.done = mul_done || div_done;
  assign rsp_o.res  = (op_q == pnht_pkg::AluMul) ? acc_q
                    : {{(pnht_pkg::MulAW-pnht_pkg::DivNW){1'b0}},
                       a_q[pnht_pkg::DivNW-1:0]};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= pnht_pkg::AluMul;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      op_q   <= req_i.op;
      step_q <= pnht_pkg::StepW'(pnht_pkg::DivNW);
    end else if (busy_q) begin
      if (mul_done || div_done) begin
        busy_q <= 1'b0;
      end else if (op_q == pnht_pkg::AluDiv) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      if (op_q == pnht_pkg::AluMul) begin
        if (b_q != '0) begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= {a_q[pnht_pkg::MulAW-2:0], 1'b0};
          b_q <= {1'b0, b_q[pnht_pkg::MulBW-1:1]};
        end
      end else if (step_q != '0) begin
        rem_q <= ge ? diff[pnht_pkg::DivDW-1:0] : rem_n[pnht_pkg::DivDW-1:0];
        a_q   <= {{(pnht_pkg::MulAW-pnht_pkg::DivNW){1'b0}},
                  a_q[pnht_pkg::DivNW-2:0], ge};
      end
    end
  end

endmodule

>>> hw/rtl/pnht_checker.sv
// Port-level checker for the pitch note hypothesis tracker, with its bind.
`include "assert_macros.svh"

module pnht_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        est_valid,
  input logic                        est_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        note_valid,
  input logic [pnht_pkg::TimeW-1:0]  note_start,
  input logic [pnht_pkg::TimeW-1:0]  note_duration,
  input logic [pnht_pkg::FreqW-1:0]  mean_frequency
);

  // Busy after taking an item
  `ASSERT_NEXT(a_busy_after_accept, est_valid && est_ready, !est_ready)

  // Never idle while a result is pending
  `ASSERT_ALWAYS(a_no_overlap, !(est_ready && res_valid))

  // Result holds until taken
  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(mean_frequency))

  // Note fields are zero when no note is reported
  `ASSERT_ALWAYS(a_zero_fields, !(res_valid && !note_valid) || (note_start == '0 && note_duration == '0 && mean_frequency == '0))

endmodule

bind pitch_note_hypothesis_tracker pnht_checker u_pnht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .est_valid      (est_i.valid),
  .est_ready      (est_i.ready),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .note_valid     (res_o.note_valid),
  .note_start     (res_o.note_start),
  .note_duration  (res_o.note_duration),
  .mean_frequency (res_o.mean_frequency)
);
